/* hdl/nta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants for the neighbour table with aging: item
// structs, status codes, table entry layout and controller states.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [15:0] MAX_AGE_RESET = 16'd2000;

  // Register index of max_age in the configuration space.
  localparam logic REG_MAX_AGE = 1'b0;

  localparam logic OP_AGE     = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_AGED     = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_REPLACED = 2'd2,
    STAT_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [31:0] current_time;
    logic [7:0]  sender_id;
    logic [31:0] sender_x;
    logic [31:0] sender_y;
    logic [15:0] sender_speed;
    logic [31:0] receiver_x;
    logic [31:0] receiver_y;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  occupancy;
    logic [4:0]  expired_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  sender;
    logic [31:0] rx_time;
    logic [31:0] sender_x;
    logic [31:0] sender_y;
    logic [15:0] speed;
    logic [31:0] receiver_x;
    logic [31:0] receiver_y;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

/* hdl/neighbor_table_with_aging.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Table of neighbour position reports keyed by sender id, aged on every
// transaction and updated by receive transactions.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted on a rising edge with start high and busy low;
// in_item carries the operation, the current time and the report. busy
// stays high while the table is scanned. The entries live in a synchronous
// memory which is read one entry per cycle, so the scan length is set by
// the single memory read port. The scan is followed by a commit state, and
// a new transaction may be started in the cycle the result appears.
// The result is shown on out_item for exactly one cycle with out_valid
// high; the receiver takes it in that cycle and cannot hold it off.
// The max_age register sits at byte address 0 of the APB port and may only
// be written while busy is low. Reset clears all valid bits, returns
// max_age to 2000 ticks and needs no clearing pass over the memory.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging
  import nta_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  in_item_t               req_r;
  logic [15:0]            max_age_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   issue_r;
  logic                   rvalid_r;
  logic [IDX_W-1:0]       eval_idx_r;
  entry_t                 rdata_r;
  logic                   match_found_r;
  logic [IDX_W-1:0]       match_idx_r;
  logic                   free_found_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic [CNT_W-1:0]       expired_r;
  logic [CNT_W-1:0]       occ_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  entry_t mem [TABLE_DEPTH];

  logic             accept;
  logic             scan_en;
  logic             commit;
  logic [31:0]      age;
  logic             cur_valid;
  logic             expire;
  logic             keep;
  logic             match_hit;
  logic             free_hit;
  logic             do_write;
  logic [IDX_W-1:0] wr_idx;
  status_t          status;
  entry_t           new_entry;
  logic             cfg_wr;

  // Controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rvalid_r && eval_idx_r == LAST_IDX) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    accept  = 1'b0;
    scan_en = 1'b0;
    commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:   scan_en = 1'b1;
      ST_COMMIT: commit  = 1'b1;
      default:   busy    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Evaluation of the entry read in the previous cycle. Aging of one entry
  // depends on that entry alone, so the match and free-slot search can use
  // its post-aging validity in the same pass.
  always_comb begin
    age       = req_r.current_time - rdata_r.rx_time;
    cur_valid = valid_r[eval_idx_r];
    expire    = rvalid_r && cur_valid && (age > {16'b0, max_age_r});
    keep      = rvalid_r && cur_valid && !expire;
    match_hit = keep && (rdata_r.sender == req_r.sender_id) && !match_found_r;
    free_hit  = rvalid_r && !keep && !free_found_r;
  end

  always_comb begin
    do_write = (req_r.op == OP_RECEIVE) && (match_found_r || free_found_r);
    wr_idx   = match_found_r ? match_idx_r : free_idx_r;
    if (req_r.op == OP_AGE) begin
      status = STAT_AGED;
    end else if (match_found_r) begin
      status = STAT_REPLACED;
    end else if (free_found_r) begin
      status = STAT_INSERTED;
    end else begin
      status = STAT_DROPPED;
    end
    new_entry.sender     = req_r.sender_id;
    new_entry.rx_time    = req_r.current_time;
    new_entry.sender_x   = req_r.sender_x;
    new_entry.sender_y   = req_r.sender_y;
    new_entry.speed      = req_r.sender_speed;
    new_entry.receiver_x = req_r.receiver_x;
    new_entry.receiver_y = req_r.receiver_y;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      idx_r         <= '0;
      issue_r       <= 1'b0;
      rvalid_r      <= 1'b0;
      eval_idx_r    <= '0;
      match_found_r <= 1'b0;
      match_idx_r   <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      expired_r     <= '0;
      occ_r         <= '0;
    end else begin
      rvalid_r <= scan_en && issue_r;
      if (accept) begin
        idx_r         <= '0;
        issue_r       <= 1'b1;
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
        expired_r     <= '0;
        occ_r         <= '0;
      end
      if (scan_en && issue_r) begin
        eval_idx_r <= idx_r;
        if (idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (scan_en) begin
        if (expire) begin
          valid_r[eval_idx_r] <= 1'b0;
          expired_r           <= expired_r + 1'b1;
        end
        if (keep) begin
          occ_r <= occ_r + 1'b1;
        end
        if (match_hit) begin
          match_found_r <= 1'b1;
          match_idx_r   <= eval_idx_r;
        end
        if (free_hit) begin
          free_found_r <= 1'b1;
          free_idx_r   <= eval_idx_r;
        end
      end
      if (commit && do_write) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Entry memory: reads happen only during the scan and the single write
  // only in the commit cycle, so the two never touch the same entry at once.
  always_ff @(posedge clk) begin
    if (scan_en && issue_r) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && do_write) begin
      mem[wr_idx] <= new_entry;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item_r.status        <= status;
      out_item_r.occupancy     <= 5'(occ_r + CNT_W'(status == STAT_INSERTED));
      out_item_r.expired_count <= 5'(expired_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= MAX_AGE_RESET;
    end else if (cfg_wr && paddr[2] == REG_MAX_AGE) begin
      max_age_r <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_AGE: prdata = {16'b0, max_age_r};
      default:     prdata = '0;
    endcase
  end

endmodule

/* hdl/nta_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nta_checker
// Port-level checks for the neighbour table with aging, bound to the top.
// ----------------------------------------------------------------------------
module nta_checker
  import nta_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input in_item_t    in_item,
  input logic        busy,
  input logic        out_valid,
  input out_item_t   out_item,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  localparam int OCC_LIMIT = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;

  // An accepted transaction keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted transaction");

  // A result lasts exactly one cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A replaced entry was valid, so the table cannot be empty afterwards.
  a_replace_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STAT_REPLACED) |-> (out_item.occupancy != 5'd0))
    else $error("replace reported with an empty table");

  // Occupancy never exceeds the table depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_item.occupancy) <= OCC_LIMIT))
    else $error("occupancy beyond the table depth");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind neighbor_table_with_aging nta_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_nta_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbour table with aging. A short table of
// hand-worked transactions is followed by phases of random report traffic at
// several max_age settings. Every result is compared with a scoreboard model
// of the table's valid bits, sender ids and receive times.
// ----------------------------------------------------------------------------
module testbench
  import nta_pkg::*;
();

  localparam int          DEPTH        = TABLE_DEPTH_DEF;
  localparam logic [2:0]  MAX_AGE_ADDR = {REG_MAX_AGE, 2'b00};
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          PHASE_ITEMS  = 330;

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Scoreboard copy of the table. Positions and speed never reach a result,
  // so only the fields that decide matching and expiry are kept.
  logic        tbl_valid  [DEPTH];
  logic [7:0]  tbl_sender [DEPTH];
  logic [31:0] tbl_time   [DEPTH];
  logic [15:0] age_limit = MAX_AGE_RESET;

  out_item_t   pending_results [$];
  vector_t     plan [$];
  logic [31:0] tick;
  int          errors = 0;
  int          sent = 0;
  int          settings = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          expiries = 0;
  int          quiet = 0;

  neighbor_table_with_aging u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Ages the table, then applies the item if it is a receive, exactly as the block should.
  function automatic out_item_t age_and_insert(in_item_t it);
    out_item_t   r;
    logic [31:0] age;
    int          hit;
    int          slot;
    int          occ;
    int          gone;
    hit = -1;
    slot = -1;
    occ = 0;
    gone = 0;
    for (int i = 0; i < DEPTH; i++) begin
      age = it.current_time - tbl_time[i];
      if (tbl_valid[i] && age > {16'h0, age_limit}) begin
        tbl_valid[i] = 1'b0;
        gone++;
      end
    end
    r.status = STAT_AGED;
    if (it.op == OP_RECEIVE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i]) begin
          if (hit < 0 && tbl_sender[i] == it.sender_id) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (hit >= 0) begin
        tbl_time[hit] = it.current_time;
        r.status = STAT_REPLACED;
      end else if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_sender[slot] = it.sender_id;
        tbl_time[slot] = it.current_time;
        r.status = STAT_INSERTED;
      end else begin
        r.status = STAT_DROPPED;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) occ++;
    end
    r.occupancy = 5'(occ);
    r.expired_count = 5'(gone);
    return r;
  endfunction

  // Hand-worked rows alternate the position and speed fields between extremes.
  function automatic void add_row(logic op, logic [31:0] t, logic [7:0] id,
                                  status_t st, int occ, int gone);
    vector_t v;
    logic    flip;
    flip = 1'(plan.size() % 2);
    v.item.op = op;
    v.item.current_time = t;
    v.item.sender_id = id;
    v.item.sender_x = flip ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v.item.sender_y = flip ? 32'h7FFF_FFFF : 32'h8000_0000;
    v.item.sender_speed = flip ? 16'hFFFF : 16'h0000;
    v.item.receiver_x = flip ? 32'h0000_0000 : 32'hFFFF_FFFF;
    v.item.receiver_y = flip ? 32'hFFFF_FFFF : 32'h0000_0000;
    v.known = 1'b1;
    v.want.status = st;
    v.want.occupancy = 5'(occ);
    v.want.expired_count = 5'(gone);
    plan.push_back(v);
  endfunction

  // Mostly small time steps so that entries live long enough to fill the
  // table, with landings right on an entry's expiry edge, jumps past max_age,
  // steps backwards and arbitrary times mixed in.
  function automatic in_item_t make_item();
    in_item_t it;
    int       pick;
    int       slot;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      tick = tick + $urandom_range(0, age_limit / 32 + 1);
    end else if (pick < 85) begin
      slot = $urandom_range(0, DEPTH - 1);
      if (tbl_valid[slot]) tick = tbl_time[slot] + age_limit + $urandom_range(0, 1);
    end else if (pick < 92) begin
      tick = tick + age_limit + $urandom_range(0, 3);
    end else if (pick < 96) begin
      tick = tick - $urandom_range(1, 100);
    end else begin
      tick = $urandom();
    end
    it.op = ($urandom_range(0, 99) < 80) ? OP_RECEIVE : OP_AGE;
    it.current_time = tick;
    it.sender_id = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 19))
                                               : 8'($urandom_range(0, 255));
    it.sender_x = $urandom();
    it.sender_y = $urandom();
    it.sender_speed = 16'($urandom_range(0, 65535));
    it.receiver_x = $urandom();
    it.receiver_y = $urandom();
    return it;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Called on a rising edge; returns on the edge at which the block takes it.
  task automatic issue(in_item_t it, bit known, out_item_t want);
    out_item_t predicted;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = age_and_insert(it);
    pending_results.push_back(known ? want : predicted);
    sent++;
  endtask

  task automatic idle(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_max_age(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_AGE_ADDR;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    age_limit = value;
    settings++;
  endtask

  task automatic verify_max_age();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MAX_AGE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("max_age readback", prdata, {16'h0, age_limit});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      status_seen[out_item.status]++;
      if (pending_results.size() == 0) begin
        report("result arrived with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        expiries += want.expired_count;
        check_field("status", out_item.status, want.status);
        check_field("occupancy", out_item.occupancy, want.occupancy);
        check_field("expired_count", out_item.expired_count, want.expired_count);
      end
    end
  end

  // Ends the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("neighbor_table_with_aging regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [15:0] limits [6];
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_sender[i] = '0;
      tbl_time[i] = '0;
    end
    limits = '{16'd2000, 16'd0, 16'd65535, 16'd1, 16'd300, 16'd0};
    limits[5] = 16'($urandom_range(2, 65534));

    // Empty table, first inserts at both ends of the id range, a replace,
    // then the expiry edge: an age of exactly max_age survives, one more goes.
    add_row(OP_AGE,     32'hFFFF_FFFF, 8'd0,   STAT_AGED,     0, 0);
    add_row(OP_RECEIVE, 32'd100,       8'd0,   STAT_INSERTED, 1, 0);
    add_row(OP_RECEIVE, 32'd200,       8'd255, STAT_INSERTED, 2, 0);
    add_row(OP_RECEIVE, 32'd300,       8'd0,   STAT_REPLACED, 2, 0);
    add_row(OP_AGE,     32'd2300,      8'd0,   STAT_AGED,     1, 1);
    add_row(OP_AGE,     32'd2301,      8'd0,   STAT_AGED,     0, 1);
    for (int k = 1; k <= DEPTH; k++) begin
      add_row(OP_RECEIVE, 32'd3000, 8'(k), STAT_INSERTED, k, 0);
    end
    // A full table drops a stranger but still replaces a known sender; time
    // stepping back by one tick makes every age wrap and expire.
    add_row(OP_RECEIVE, 32'd3000, 8'd200, STAT_DROPPED,  DEPTH, 0);
    add_row(OP_RECEIVE, 32'd3000, 8'd5,   STAT_REPLACED, DEPTH, 0);
    add_row(OP_AGE,     32'd2999, 8'd5,   STAT_AGED,     0,     DEPTH);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    verify_max_age();

    foreach (plan[i]) begin
      issue(plan[i].item, plan[i].known, plan[i].want);
      idle(gap_len());
    end

    foreach (limits[p]) begin
      drain();
      write_max_age(limits[p]);
      verify_max_age();
      tick = (p == 3) ? 32'hFFFF_F000 : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(make_item(), 1'b0, '0);
        if (n % 110 == 109) begin
          drain();
        end else begin
          idle(gap_len());
        end
      end
    end

    drain();
    repeat (3 * (DEPTH + 2)) @(posedge clk);
    $display("Covered %0d transactions over the reset max_age and %0d written settings.",
             sent, settings);
    $display("Seen %0d age-only, %0d inserts, %0d replaces, %0d drops; %0d entries expired.",
             status_seen[STAT_AGED], status_seen[STAT_INSERTED],
             status_seen[STAT_REPLACED], status_seen[STAT_DROPPED], expiries);
    if (errors == 0) begin
      $display("neighbor_table_with_aging regression: pass");
    end else begin
      $display("neighbor_table_with_aging regression: fail");
    end
    $finish;
  end

endmodule
